@@ src/swk_pkg.sv @@
// shared types and constants of the sliding window rank-order filter
// no dependencies; imported by swk_ctrl, swk_datapath and the top level
package swk_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANK_SELECT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;
    localparam logic [CFG_DATA_BITS-1:0] RANK_SELECT_RESET = 7'd1;

    typedef struct packed {
        logic accept;
        logic remove;
        logic insert;
        logic load_out;
    } swk_cmd_t;

    typedef struct packed {
        logic full;
        logic last;
        logic out_busy;
    } swk_status_t;

endpackage

@@ src/sliding_window_kth_smallest.sv @@
// top level of the sliding window rank-order filter
// depends on swk_pkg, swk_ctrl and swk_datapath
//
// usage:
//   s_ channel carries one signed sample per transaction in s_tdata and a
//   restart flag in s_tuser; restart empties the window before the sample
//   is taken. m_ channel returns the rank_select-th smallest sample of the
//   full window, one transaction per sample from the one that fills it.
//   cfg channel writes register 0 (window_size, also empties the window)
//   or register 1 (rank_select); cfg_ready is always high, write only idle.
// sequence:
//   a sample that only fills is accepted with a ring read, then inserted; a full-window
//   sample is accepted with a ring read, removed from the sorted cell chain, then inserted,
//   and when it gives a result the output register is loaded after insertion.
//   the next sample is taken while a result waits in the output register.
// reset:
//   aresetn low empties the window, clears the output and restores
//   window_size 3 and rank_select 1.
// stall:
//   if m_tready stays low, one result waits and the block holds the next
//   result, and its input, until the waiting result is taken.
module sliding_window_kth_smallest #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    input  logic [0:0]                               s_tuser,  // restart
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // ranked_value
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [swk_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [swk_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
    import swk_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    swk_cmd_t               cmd;
    swk_status_t            status;
    logic [SAMPLE_BITS-1:0] m_value;

    assign cfg_ready = 1'b1;
    assign m_tdata   = TDATA_W'(m_value);

    swk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swk_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .s_restart (s_tuser[0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_value   (m_value),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ src/swk_ctrl.sv @@
// controller state machine of the rank-order filter
// depends on swk_pkg; drives swk_datapath through command and status structs
module swk_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  swk_pkg::swk_status_t status,
    output swk_pkg::swk_cmd_t    cmd
);
    import swk_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REMOVE = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.full ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = status.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.remove, cmd.insert, cmd.load_out}))
        else $error("more than one datapath command at once");

    a_remove_then_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |=> cmd.insert)
        else $error("removal not followed by insertion");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.remove || cmd.insert) |-> !s_tready)
        else $error("input ready while an update is in progress");

endmodule

@@ src/swk_datapath.sv @@
// datapath of the rank-order filter: config registers, arrival ring memory,
// sorted cell chain, fill and oldest counters and the output register; uses swk_pkg
module swk_datapath #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [swk_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [swk_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [SAMPLE_BITS-1:0]              s_sample,
    input  logic                                s_restart,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [SAMPLE_BITS-1:0]              m_value,
    input  swk_pkg::swk_cmd_t                   cmd,
    output swk_pkg::swk_status_t                status
);
    import swk_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > CFG_DATA_BITS) ? CNT_W : CFG_DATA_BITS;

    logic [CFG_DATA_BITS-1:0] window_size_reg;
    logic [CFG_DATA_BITS-1:0] rank_select_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         ptr_reg;
    logic                     replace_reg;
    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   out_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cells_reg  [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cells_next [WINDOW_MAX];

    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] rank_ext;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] r_eff;
    logic [CMP_W-1:0] fill_ext;
    logic [CMP_W-1:0] ptr_ext;
    logic [IDX_W-1:0] rank_idx;
    logic [IDX_W-1:0] ptr_adv;
    logic             ring_we;
    logic [IDX_W-1:0] ring_waddr;
    logic [WINDOW_MAX-1:0] ge_ins;
    logic [WINDOW_MAX-1:0] ge_rem;

    assign size_ext = CMP_W'(window_size_reg);
    assign rank_ext = CMP_W'(rank_select_reg);
    assign fill_ext = CMP_W'(fill_reg);
    assign ptr_ext  = CMP_W'(ptr_reg);

    always_comb begin
        priority if (size_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (size_ext > CMP_W'(WINDOW_MAX)) begin
            w_eff = CMP_W'(WINDOW_MAX);
        end else begin
            w_eff = size_ext;
        end
        priority if (rank_ext == '0) begin
            r_eff = CMP_W'(1);
        end else if (rank_ext > w_eff) begin
            r_eff = w_eff;
        end else begin
            r_eff = rank_ext;
        end
    end

    assign rank_idx = IDX_W'(r_eff - CMP_W'(1));
    assign ptr_adv  = (ptr_ext + CMP_W'(1) == w_eff) ? '0 : ptr_reg + IDX_W'(1);

    assign status.full     = !s_restart && (fill_ext == w_eff);
    assign status.last     = (fill_ext == w_eff - CMP_W'(1));
    assign status.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_reg;

    // sorted cell chain: every cell decides its next value from its neighbors
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            assign ge_ins[gi] = (CNT_W'(gi) >= fill_reg) || (cells_reg[gi] > sample_reg);
            assign ge_rem[gi] = (CNT_W'(gi) >= fill_reg) || (cells_reg[gi] >= old_reg);

            always_comb begin
                cells_next[gi] = cells_reg[gi];
                if (cmd.remove && ge_rem[gi]) begin
                    if (gi < WINDOW_MAX - 1) begin
                        cells_next[gi] = cells_reg[(gi + 1) % WINDOW_MAX];
                    end
                end
                if (cmd.insert && ge_ins[gi]) begin
                    if (gi == 0) begin
                        cells_next[gi] = sample_reg;
                    end else if (!ge_ins[(gi + WINDOW_MAX - 1) % WINDOW_MAX]) begin
                        cells_next[gi] = sample_reg;
                    end else begin
                        cells_next[gi] = cells_reg[(gi + WINDOW_MAX - 1) % WINDOW_MAX];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                cells_reg[gi] <= cells_next[gi];
            end
        end
    endgenerate

    assign ring_we    = cmd.remove || (cmd.insert && !replace_reg);
    assign ring_waddr = cmd.remove ? ptr_reg : fill_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= sample_reg;
        end
        if (cmd.accept) begin
            old_reg <= ring_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.load_out) begin
            out_reg <= cells_reg[rank_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_SIZE_RESET;
            rank_select_reg <= RANK_SELECT_RESET;
            fill_reg        <= '0;
            ptr_reg         <= '0;
            replace_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_WINDOW_SIZE) begin
                window_size_reg <= cfg_data;
                fill_reg        <= '0;
                ptr_reg         <= '0;
            end else if (cfg_valid && cfg_index == CFG_RANK_SELECT) begin
                rank_select_reg <= cfg_data;
            end
            if (cmd.accept) begin
                replace_reg <= status.full;
                if (s_restart) begin
                    fill_reg <= '0;
                    ptr_reg  <= '0;
                end
            end
            if (cmd.remove) begin
                fill_reg <= fill_reg - CNT_W'(1);
                ptr_reg  <= ptr_adv;
            end
            if (cmd.insert) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_fill_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_ext <= w_eff)
        else $error("fill count beyond window size");

    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_ext < w_eff)
        else $error("oldest pointer beyond window size");

    a_remove_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |-> (fill_ext == w_eff) && replace_reg)
        else $error("removal from a window that is not full");

endmodule
